FILE: sv/cslim_pkg.sv
// Shared types and constants for the dq current vector magnitude limiter.
// No dependencies; imported by every cell and by the top level.
`default_nettype none

package cslim_pkg;

  // Reset value of the maximum current in whole amps, before the fraction shift.
  localparam int unsigned RESET_MAX_AMPS = 200;

  // Per-request control flags that travel beside the data through every cell.
  typedef struct packed {
    logic vld;
    logic hit;     // an axis clamp fired
    logic scale;   // the circular scaling applies
    logic sgn_id;  // d-axis result is negative
    logic sgn_iq;  // q-axis result is negative
  } ctl_t;

endpackage

`default_nettype wire

FILE: sv/cslim_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cell.
// Depends on cslim_pkg for the control struct.
`default_nettype none

module cslim_sqrt_cell #(
  parameter int unsigned CW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cslim_pkg::ctl_t     ctl_i,
  input  logic [CW-2:0]       a_id_i,
  input  logic [CW-2:0]       a_iq_i,
  input  logic [2*CW-1:0]     rad_i,
  input  logic [CW:0]         rem_i,
  input  logic [CW-1:0]       root_i,
  output cslim_pkg::ctl_t     ctl_o,
  output logic [CW-2:0]       a_id_o,
  output logic [CW-2:0]       a_iq_o,
  output logic [2*CW-1:0]     rad_o,
  output logic [CW:0]         rem_o,
  output logic [CW-1:0]       root_o
);
  import cslim_pkg::*;

  ctl_t              ctl_r;
  logic [CW-2:0]     a_id_r, a_iq_r;
  logic [2*CW-1:0]   rad_r, rad_nxt;
  logic [CW:0]       rem_r, rem_nxt;
  logic [CW-1:0]     root_r, root_nxt;
  logic [CW+1:0]     cur, trial, diff;
  logic              take;

  // The remainder entering any cell is below 2^CW, so its top bit is dropped
  // before the next two radicand bits are brought down.
  always_comb begin
    cur      = {rem_i[CW-1:0], rad_i[2*CW-1 -: 2]};
    trial    = {root_i, 2'b01};
    take     = (cur >= trial);
    diff     = cur - trial;
    rem_nxt  = take ? diff[CW:0] : cur[CW:0];
    root_nxt = {root_i[CW-2:0], take};
    rad_nxt  = {rad_i[2*CW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_id_r <= a_id_i;
      a_iq_r <= a_iq_i;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign a_id_o = a_id_r;
  assign a_iq_o = a_iq_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

`default_nettype wire

FILE: sv/cslim_div_cell.sv
// One cell of the divider chain: one quotient bit per cell for both axes.
// Depends on cslim_pkg for the control struct.
`default_nettype none

module cslim_div_cell #(
  parameter int unsigned CW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cslim_pkg::ctl_t     ctl_i,
  input  logic [CW-2:0]       a_id_i,
  input  logic [CW-2:0]       a_iq_i,
  input  logic [CW-1:0]       root_i,
  input  logic [CW-1:0]       rem_id_i,
  input  logic [CW-1:0]       rem_iq_i,
  input  logic [CW-2:0]       dvd_id_i,
  input  logic [CW-2:0]       dvd_iq_i,
  input  logic [CW-2:0]       q_id_i,
  input  logic [CW-2:0]       q_iq_i,
  output cslim_pkg::ctl_t     ctl_o,
  output logic [CW-2:0]       a_id_o,
  output logic [CW-2:0]       a_iq_o,
  output logic [CW-1:0]       root_o,
  output logic [CW-1:0]       rem_id_o,
  output logic [CW-1:0]       rem_iq_o,
  output logic [CW-2:0]       dvd_id_o,
  output logic [CW-2:0]       dvd_iq_o,
  output logic [CW-2:0]       q_id_o,
  output logic [CW-2:0]       q_iq_o
);
  import cslim_pkg::*;

  ctl_t            ctl_r;
  logic [CW-2:0]   a_id_r, a_iq_r;
  logic [CW-1:0]   root_r;
  logic [CW-1:0]   rem_id_r, rem_iq_r, rem_id_nxt, rem_iq_nxt;
  logic [CW-2:0]   dvd_id_r, dvd_iq_r, dvd_id_nxt, dvd_iq_nxt;
  logic [CW-2:0]   q_id_r, q_iq_r, q_id_nxt, q_iq_nxt;
  logic [CW:0]     cur_id, cur_iq, diff_id, diff_iq;
  logic            take_id, take_iq;

  // Restoring step: bring down the next dividend bit and subtract the root
  // where it fits. The remainder always stays below the root.
  always_comb begin
    cur_id     = {rem_id_i, dvd_id_i[CW-2]};
    take_id    = (cur_id >= {1'b0, root_i});
    diff_id    = cur_id - {1'b0, root_i};
    rem_id_nxt = take_id ? diff_id[CW-1:0] : cur_id[CW-1:0];
    dvd_id_nxt = {dvd_id_i[CW-3:0], 1'b0};
    q_id_nxt   = {q_id_i[CW-3:0], take_id};
  end

  always_comb begin
    cur_iq     = {rem_iq_i, dvd_iq_i[CW-2]};
    take_iq    = (cur_iq >= {1'b0, root_i});
    diff_iq    = cur_iq - {1'b0, root_i};
    rem_iq_nxt = take_iq ? diff_iq[CW-1:0] : cur_iq[CW-1:0];
    dvd_iq_nxt = {dvd_iq_i[CW-3:0], 1'b0};
    q_iq_nxt   = {q_iq_i[CW-3:0], take_iq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_id_r   <= a_id_i;
      a_iq_r   <= a_iq_i;
      root_r   <= root_i;
      rem_id_r <= rem_id_nxt;
      rem_iq_r <= rem_iq_nxt;
      dvd_id_r <= dvd_id_nxt;
      dvd_iq_r <= dvd_iq_nxt;
      q_id_r   <= q_id_nxt;
      q_iq_r   <= q_iq_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign a_id_o   = a_id_r;
  assign a_iq_o   = a_iq_r;
  assign root_o   = root_r;
  assign rem_id_o = rem_id_r;
  assign rem_iq_o = rem_iq_r;
  assign dvd_id_o = dvd_id_r;
  assign dvd_iq_o = dvd_iq_r;
  assign q_id_o   = q_id_r;
  assign q_iq_o   = q_iq_r;

endmodule

`default_nettype wire

FILE: sv/current_setpoint_circular_limiter_core.sv
// Top level of the dq current vector magnitude limiter: clamp, square, sum,
// square root chain, multiply, divider chain and output register.
// Depends on cslim_pkg, cslim_sqrt_cell and cslim_div_cell.
//
//   Channel   Ports                                   Carries
//   input     in_tvalid / in_tready / in_tdata        id_request, iq_request
//   result    out_tvalid / out_tready / out_tdata     id_limited, iq_limited
//             out_tuser                               was_clamped
//   config    cfg_wr_en / cfg_wr_data                 max_current
//
// One request is taken per cycle while the pipe advances; each passes every
// stage named above in order, one root bit per square root cell and one
// quotient bit per divider cell. The whole pipe advances together and halts
// only while the output register holds a request that is not taken.
// Reset clears the valid flags and loads max_current with 200 A.
`default_nettype none

module current_setpoint_circular_limiter_core #(
  parameter int unsigned CURRENT_WIDTH = 16,
  parameter int unsigned FRACTION_BITS = 4,
  localparam int unsigned TDATA_W = ((2 * CURRENT_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [TDATA_W-1:0]       in_tdata,    // id_request, iq_request
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TDATA_W-1:0]       out_tdata,   // id_limited, iq_limited
  output logic                     out_tuser,   // was_clamped
  input  logic                     cfg_wr_en,
  input  logic [CURRENT_WIDTH-2:0] cfg_wr_data  // max_current
);
  import cslim_pkg::*;

  localparam int unsigned CW = CURRENT_WIDTH;
  localparam logic [CW-2:0] MAX_RST = (CW-1)'(RESET_MAX_AMPS << FRACTION_BITS);

  logic          adv;
  logic [CW-2:0] max_current_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_current_r <= MAX_RST;
    end else if (cfg_wr_en) begin
      max_current_r <= cfg_wr_data;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Clamp stage: each axis is reduced to a magnitude and a sign.
  logic signed [CW-1:0] id_s, iq_s, lim_s, nlim_s, id_neg, iq_neg;
  ctl_t                 c1_nxt, c1_r;
  logic [CW-2:0]        a1_id_nxt, a1_iq_nxt, a1_id_r, a1_iq_r;

  always_comb begin
    id_s   = $signed(in_tdata[CW-1:0]);
    iq_s   = $signed(in_tdata[2*CW-1:CW]);
    lim_s  = $signed({1'b0, max_current_r});
    nlim_s = -lim_s;
    id_neg = -id_s;
    iq_neg = -iq_s;
    c1_nxt = '0;
    c1_nxt.vld = in_tvalid;
    if (id_s > lim_s) begin
      a1_id_nxt     = max_current_r;
      c1_nxt.sgn_id = 1'b0;
      c1_nxt.hit    = 1'b1;
    end else if (id_s < nlim_s) begin
      a1_id_nxt     = max_current_r;
      c1_nxt.sgn_id = 1'b1;
      c1_nxt.hit    = 1'b1;
    end else begin
      a1_id_nxt     = id_s[CW-1] ? id_neg[CW-2:0] : id_s[CW-2:0];
      c1_nxt.sgn_id = id_s[CW-1];
    end
    if (iq_s > lim_s) begin
      a1_iq_nxt     = max_current_r;
      c1_nxt.sgn_iq = 1'b0;
      c1_nxt.hit    = 1'b1;
    end else if (iq_s < nlim_s) begin
      a1_iq_nxt     = max_current_r;
      c1_nxt.sgn_iq = 1'b1;
      c1_nxt.hit    = 1'b1;
    end else begin
      a1_iq_nxt     = iq_s[CW-1] ? iq_neg[CW-2:0] : iq_s[CW-2:0];
      c1_nxt.sgn_iq = iq_s[CW-1];
    end
  end

  // Square stage.
  ctl_t            c2_r;
  logic [CW-2:0]   a2_id_r, a2_iq_r;
  logic [2*CW-3:0] sq_id_r, sq_iq_r, lim_sq_r;

  // Sum and compare stage.
  ctl_t            c3_nxt, c3_r;
  logic [CW-2:0]   a3_id_r, a3_iq_r;
  logic [2*CW-2:0] mag_sq;
  logic [2*CW-1:0] rad3_r;

  always_comb begin
    mag_sq       = {1'b0, sq_id_r} + {1'b0, sq_iq_r};
    c3_nxt       = c2_r;
    c3_nxt.scale = (mag_sq > {1'b0, lim_sq_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c1_r <= c1_nxt;
      c2_r <= c1_r;
      c3_r <= c3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_id_r  <= a1_id_nxt;
      a1_iq_r  <= a1_iq_nxt;
      a2_id_r  <= a1_id_r;
      a2_iq_r  <= a1_iq_r;
      sq_id_r  <= (2*CW-2)'(a1_id_r) * (2*CW-2)'(a1_id_r);
      sq_iq_r  <= (2*CW-2)'(a1_iq_r) * (2*CW-2)'(a1_iq_r);
      lim_sq_r <= (2*CW-2)'(max_current_r) * (2*CW-2)'(max_current_r);
      a3_id_r  <= a2_id_r;
      a3_iq_r  <= a2_iq_r;
      rad3_r   <= {1'b0, mag_sq};
    end
  end

  // Square root chain: CW cells, cell k produces root bit CW-1-k.
  ctl_t            sq_ctl  [0:CW];
  logic [CW-2:0]   sq_a_id [0:CW];
  logic [CW-2:0]   sq_a_iq [0:CW];
  logic [2*CW-1:0] sq_rad  [0:CW];
  logic [CW:0]     sq_rem  [0:CW];
  logic [CW-1:0]   sq_root [0:CW];

  assign sq_ctl[0]  = c3_r;
  assign sq_a_id[0] = a3_id_r;
  assign sq_a_iq[0] = a3_iq_r;
  assign sq_rad[0]  = rad3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    cslim_sqrt_cell #(.CW(CW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .ctl_i  (sq_ctl[k]),
      .a_id_i (sq_a_id[k]),
      .a_iq_i (sq_a_iq[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .ctl_o  (sq_ctl[k+1]),
      .a_id_o (sq_a_id[k+1]),
      .a_iq_o (sq_a_iq[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // Multiply stage: each magnitude times the maximum current.
  ctl_t            c4_r;
  logic [CW-2:0]   a4_id_r, a4_iq_r;
  logic [CW-1:0]   root4_r;
  logic [2*CW-3:0] p_id_r, p_iq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
    end else if (adv) begin
      c4_r <= sq_ctl[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_id_r <= sq_a_id[CW];
      a4_iq_r <= sq_a_iq[CW];
      root4_r <= sq_root[CW];
      p_id_r  <= (2*CW-2)'(sq_a_id[CW]) * (2*CW-2)'(max_current_r);
      p_iq_r  <= (2*CW-2)'(sq_a_iq[CW]) * (2*CW-2)'(max_current_r);
    end
  end

  // Divider chain: the quotient never exceeds max_current, so CW-1 bits do.
  localparam int unsigned DN = CW - 1;

  ctl_t          dv_ctl    [0:DN];
  logic [CW-2:0] dv_a_id   [0:DN];
  logic [CW-2:0] dv_a_iq   [0:DN];
  logic [CW-1:0] dv_root   [0:DN];
  logic [CW-1:0] dv_rem_id [0:DN];
  logic [CW-1:0] dv_rem_iq [0:DN];
  logic [CW-2:0] dv_dvd_id [0:DN];
  logic [CW-2:0] dv_dvd_iq [0:DN];
  logic [CW-2:0] dv_q_id   [0:DN];
  logic [CW-2:0] dv_q_iq   [0:DN];

  assign dv_ctl[0]    = c4_r;
  assign dv_a_id[0]   = a4_id_r;
  assign dv_a_iq[0]   = a4_iq_r;
  assign dv_root[0]   = root4_r;
  assign dv_rem_id[0] = {1'b0, p_id_r[2*CW-3:CW-1]};
  assign dv_rem_iq[0] = {1'b0, p_iq_r[2*CW-3:CW-1]};
  assign dv_dvd_id[0] = p_id_r[CW-2:0];
  assign dv_dvd_iq[0] = p_iq_r[CW-2:0];
  assign dv_q_id[0]   = '0;
  assign dv_q_iq[0]   = '0;

  for (genvar k = 0; k < DN; k++) begin : g_div
    cslim_div_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .ctl_i    (dv_ctl[k]),
      .a_id_i   (dv_a_id[k]),
      .a_iq_i   (dv_a_iq[k]),
      .root_i   (dv_root[k]),
      .rem_id_i (dv_rem_id[k]),
      .rem_iq_i (dv_rem_iq[k]),
      .dvd_id_i (dv_dvd_id[k]),
      .dvd_iq_i (dv_dvd_iq[k]),
      .q_id_i   (dv_q_id[k]),
      .q_iq_i   (dv_q_iq[k]),
      .ctl_o    (dv_ctl[k+1]),
      .a_id_o   (dv_a_id[k+1]),
      .a_iq_o   (dv_a_iq[k+1]),
      .root_o   (dv_root[k+1]),
      .rem_id_o (dv_rem_id[k+1]),
      .rem_iq_o (dv_rem_iq[k+1]),
      .dvd_id_o (dv_dvd_id[k+1]),
      .dvd_iq_o (dv_dvd_iq[k+1]),
      .q_id_o   (dv_q_id[k+1]),
      .q_iq_o   (dv_q_iq[k+1])
    );
  end

  // Output stage: pick the scaled or the clamped magnitude and restore sign.
  ctl_t                 cf;
  logic [CW-2:0]        val_id, val_iq;
  logic [CW-1:0]        mag_id, mag_iq, res_id, res_iq;
  logic                 out_tvalid_r;
  logic [TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic                 out_tuser_r, out_tuser_nxt;

  always_comb begin
    cf            = dv_ctl[DN];
    val_id        = cf.scale ? dv_q_id[DN] : dv_a_id[DN];
    val_iq        = cf.scale ? dv_q_iq[DN] : dv_a_iq[DN];
    mag_id        = {1'b0, val_id};
    mag_iq        = {1'b0, val_iq};
    res_id        = cf.sgn_id ? -mag_id : mag_id;
    res_iq        = cf.sgn_iq ? -mag_iq : mag_iq;
    out_tdata_nxt = TDATA_W'({res_iq, res_id});
    out_tuser_nxt = cf.hit | cf.scale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= cf.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for current_setpoint_circular_limiter_core: directed corner
// requests, then random requests over several max_current settings, all scored in order.
// Depends on cslim_pkg and the limiter core.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cslim_pkg::*;

  localparam int unsigned CUR_W = 16;
  localparam int unsigned FRAC_W = 4;
  localparam int unsigned NUM_DIRECTED = 23;
  localparam int unsigned PHASE_LEN = 60;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned CALM_PHASE = 2;
  localparam int unsigned HOLD_AT = NUM_DIRECTED + 3 * PHASE_LEN + 4;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned IDLE_PCT = 8;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic signed [CUR_W-1:0] id;
    logic signed [CUR_W-1:0] iq;
    logic                    hit;
  } limited_t;

  typedef struct packed {
    logic [CUR_W-2:0]        ceiling;
    logic signed [CUR_W-1:0] id;
    logic signed [CUR_W-1:0] iq;
    bit                      typed;
    logic signed [CUR_W-1:0] want_id;
    logic signed [CUR_W-1:0] want_iq;
    logic                    want_hit;
  } setpoint_case_t;

  // Corner requests; rows marked TYPED carry a hand-derived answer.
  localparam setpoint_case_t SETPOINT_CASES [NUM_DIRECTED] = '{
    '{15'd3200, 16'sd0, 16'sd0, TYPED, 16'sd0, 16'sd0, 1'b0},
    '{15'd3200, 16'sd3200, 16'sd0, TYPED, 16'sd3200, 16'sd0, 1'b0},
    '{15'd3200, 16'sd3201, 16'sd0, TYPED, 16'sd3200, 16'sd0, 1'b1},
    '{15'd3200, 16'sd0, 16'h8000, TYPED, 16'sd0, -16'sd3200, 1'b1},
    '{15'd3200, 16'h8000, 16'sd0, TYPED, -16'sd3200, 16'sd0, 1'b1},
    '{15'd3200, 16'sd32767, 16'sd32767, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd3200, 16'h8000, 16'h8000, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd3200, 16'sd2000, 16'sd3000, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd3200, -16'sd1000, -16'sd3000, TYPED, -16'sd1000, -16'sd3000, 1'b0},
    '{15'd3200, 16'sd32767, -16'sd5, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd0, 16'sd0, 16'sd0, TYPED, 16'sd0, 16'sd0, 1'b0},
    '{15'd0, 16'sd5, -16'sd7, TYPED, 16'sd0, 16'sd0, 1'b1},
    '{15'd0, 16'h8000, 16'sd32767, TYPED, 16'sd0, 16'sd0, 1'b1},
    '{15'd0, 16'sd0, 16'sd1, TYPED, 16'sd0, 16'sd0, 1'b1},
    // The scaling runs here but leaves the values as they were.
    '{15'd1, 16'sd1, 16'sd1, TYPED, 16'sd1, 16'sd1, 1'b1},
    '{15'd1, -16'sd1, 16'sd1, TYPED, -16'sd1, 16'sd1, 1'b1},
    '{15'd1, 16'sd1, 16'sd0, TYPED, 16'sd1, 16'sd0, 1'b0},
    '{15'd32767, 16'sd32767, 16'sd0, TYPED, 16'sd32767, 16'sd0, 1'b0},
    '{15'd32767, 16'h8000, 16'sd0, TYPED, -16'sd32767, 16'sd0, 1'b1},
    '{15'd32767, 16'sd0, -16'sd32767, TYPED, 16'sd0, -16'sd32767, 1'b0},
    '{15'd32767, 16'sd32767, 16'sd32767, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd32767, 16'h8000, 16'h8000, PREDICTED, 16'sd0, 16'sd0, 1'b0},
    '{15'd32767, 16'sd23170, 16'sd23170, PREDICTED, 16'sd0, 16'sd0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // id_request, iq_request
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // id_limited, iq_limited
  logic        out_tuser;    // was_clamped
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;  // max_current

  logic [CUR_W-2:0] ceiling_q;
  limited_t         limits_due[$];
  bit               calm;
  int unsigned      requests_sent;
  int unsigned      results_seen;
  int unsigned      flagged_seen;
  int unsigned      input_stalls;
  int unsigned      ceilings_used;
  int unsigned      mismatches;

  current_setpoint_circular_limiter_core #(
    .CURRENT_WIDTH(CUR_W),
    .FRACTION_BITS(FRAC_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Clamp both axes, then pull the vector back onto the circle if it is still outside.
  function automatic limited_t limit_setpoint(logic [CUR_W-2:0] ceiling,
                                              logic signed [CUR_W-1:0] id_req,
                                              logic signed [CUR_W-1:0] iq_req);
    longint   lim;
    longint   d;
    longint   q;
    longint   mag;
    longint   root;
    longint   trial;
    int       b;
    limited_t r;
    lim = longint'(ceiling);
    d = id_req;
    q = iq_req;
    r.hit = 1'b0;
    if (d > lim) begin
      d = lim;
      r.hit = 1'b1;
    end
    if (d < -lim) begin
      d = -lim;
      r.hit = 1'b1;
    end
    if (q > lim) begin
      q = lim;
      r.hit = 1'b1;
    end
    if (q < -lim) begin
      q = -lim;
      r.hit = 1'b1;
    end
    mag = d * d + q * q;
    if (mag > lim * lim) begin
      // Floor square root, one bit at a time from the top; the sum stays below 2^32.
      root = 0;
      for (b = 16; b >= 0; b--) begin
        trial = root + (longint'(1) << b);
        if (trial * trial <= mag) root = trial;
      end
      d = (d * lim) / root;
      q = (q * lim) / root;
      r.hit = 1'b1;
    end
    r.id = d[CUR_W-1:0];
    r.iq = q[CUR_W-1:0];
    return r;
  endfunction

  // Two of the five draws fall around the ceiling, so that both clamping and scaling fire often.
  function automatic logic signed [CUR_W-1:0] pick_current(logic [CUR_W-2:0] ceiling);
    int lim;
    int v;
    lim = int'(ceiling);
    case ($urandom_range(0, 4))
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 2 * lim + 2)) - lim - 1;
      2: begin
        v = lim + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: v = int'($urandom_range(0, 1) == 1 ? 32767 - $urandom_range(0, 3)
                                             : -32768 + $urandom_range(0, 3));
      default: v = int'($urandom_range(0, 64)) - 32;
    endcase
    return v[CUR_W-1:0];
  endfunction

  task automatic send_request(logic signed [CUR_W-1:0] id_req,
                              logic signed [CUR_W-1:0] iq_req,
                              bit typed, limited_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {iq_req, id_req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    limits_due.push_back(typed ? want : limit_setpoint(ceiling_q, id_req, iq_req));
    requests_sent++;
  endtask

  // Every request yields one result, so an empty queue means an empty pipe.
  task automatic settle_pipe();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (limits_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_ceiling(logic [CUR_W-2:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ceiling_q = value;
    ceilings_used++;
  endtask

  initial begin
    limited_t         none;
    logic [CUR_W-2:0] pick;
    int unsigned      i;
    int unsigned      p;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    none        = '0;
    ceiling_q   = (CUR_W - 1)'(RESET_MAX_AMPS << FRAC_W);
    ceilings_used = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (SETPOINT_CASES[i].ceiling != ceiling_q) begin
        settle_pipe();
        set_ceiling(SETPOINT_CASES[i].ceiling);
      end
      send_request(SETPOINT_CASES[i].id, SETPOINT_CASES[i].iq, SETPOINT_CASES[i].typed,
                   '{SETPOINT_CASES[i].want_id, SETPOINT_CASES[i].want_iq,
                     SETPOINT_CASES[i].want_hit});
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       pick = 15'h7fff;
        2:       pick = 15'd3200;
        4:       pick = 15'd0;
        5:       pick = 15'($urandom_range(1, 64));
        default: pick = 15'($urandom);
      endcase
      settle_pipe();
      set_ceiling(pick);
      calm = (p == CALM_PHASE);
      for (i = 0; i < PHASE_LEN; i++)
        send_request(pick_current(ceiling_q), pick_current(ceiling_q), PREDICTED, none);
    end

    settle_pipe();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over %0d max_current settings; %0d results, %0d flagged.",
             requests_sent, ceilings_used, results_seen, flagged_seen);
    $display("Input held back for %0d cycles; %0d mismatches.", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("current_setpoint_circular_limiter_core verification clean");
    end else begin
      $display("current_setpoint_circular_limiter_core verification failed");
    end
    $finish;
  end

  // Result side: random back-pressure outside the calm phase, plus one long hold-off that fills the pipe.
  initial begin
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    limited_t                due;
    logic signed [CUR_W-1:0] got_id;
    logic signed [CUR_W-1:0] got_iq;
    got_id = out_tdata[CUR_W-1:0];
    got_iq = out_tdata[2*CUR_W-1:CUR_W];
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) flagged_seen++;
      if (limits_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result id %0d iq %0d flag %0b", $time,
                 got_id, got_iq, out_tuser);
      end else begin
        due = limits_due.pop_front();
        if (got_id !== due.id) begin
          mismatches++;
          $display("%0t: id_limited expected %0d got %0d", $time, due.id, got_id);
        end
        if (got_iq !== due.iq) begin
          mismatches++;
          $display("%0t: iq_limited expected %0d got %0d", $time, due.iq, got_iq);
        end
        if (out_tuser !== due.hit) begin
          mismatches++;
          $display("%0t: was_clamped expected %0b got %0b", $time, due.hit, out_tuser);
        end
      end
    end
  end

  initial begin
    #200_000;
    $display("current_setpoint_circular_limiter_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
